// ----- hw/rtl/psum_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix sum tree package
// Shared constants, operation codes and command/status types.
// ----------------------------------------------------------------------------
package psum_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CFG_W       = 11;
    localparam int WPOS_W      = IDX_W + 2;
    localparam int DATA_W      = 32;
    localparam int IN_DATA_W   = 48;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic              func;
        logic [WPOS_W-1:0] start_pos;
        logic [DATA_W-1:0] delta;
        logic [CFG_W-1:0]  size;
    } cmd_t;

    typedef struct packed {
        logic clearing;
        logic busy;
    } psum_status_t;

endpackage : psum_pkg
`default_nettype wire

// ----- hw/rtl/psum_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix sum tree front end
// Holds the size register, accepts items, drops out-of-range updates and
// turns the rest into walk commands.
// ----------------------------------------------------------------------------
module psum_front (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire [psum_pkg::CFG_W-1:0]  cfg_data,
    input  wire                        s_tvalid,
    output logic                       s_tready,
    input  wire [psum_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire [0:0]                  s_tuser,
    input  wire                        clearing,
    output logic                       cmd_valid,
    input  wire                        cmd_ready,
    output psum_pkg::cmd_t             cmd
);
    import psum_pkg::*;

    logic [CFG_W-1:0] entries_reg;
    logic [CFG_W-1:0] entries_next;
    logic [CFG_W-1:0] active_size;
    logic [IDX_W-1:0] index;
    logic [DATA_W-1:0] delta;
    logic             func;
    logic             in_range;
    logic             keep;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        entries_next = entries_reg;
        if (cfg_valid && cfg_ready)
        begin
            entries_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= CFG_W'(MAX_ENTRIES);
        end
        else
        begin
            entries_reg <= entries_next;
        end
    end

    assign active_size = (entries_reg > CFG_W'(MAX_ENTRIES)) ? CFG_W'(MAX_ENTRIES)
                                                               : entries_reg;
    assign func     = s_tuser[0];
    assign index    = s_tdata[IDX_W-1:0];
    assign delta    = s_tdata[IDX_W +: DATA_W];
    assign in_range = CFG_W'(index) < active_size;
    assign keep     = (func == FUNC_QUERY) || in_range;

    assign s_tready  = cmd_ready && !clearing;
    assign cmd_valid = s_tvalid && s_tready && keep;

    always_comb
    begin
        cmd.func      = func;
        cmd.delta     = delta;
        cmd.size      = active_size;
        cmd.start_pos = in_range ? (WPOS_W'(index) + WPOS_W'(1)) : '0;
    end

endmodule : psum_front
`default_nettype wire

// ----- hw/rtl/psum_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix sum tree command queue
// A short first-in first-out store between the front and back ends.
// ----------------------------------------------------------------------------
module psum_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  psum_pkg::cmd_t  in_cmd,
    output logic            out_valid,
    input  wire             out_ready,
    output psum_pkg::cmd_t  out_cmd
);
    import psum_pkg::*;

    cmd_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign in_ready  = count_reg != (QPTR_W+1)'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule : psum_queue
`default_nettype wire

// ----- hw/rtl/psum_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix sum tree back end
// Clears the node memory after reset, then walks the tree one node per cycle
// for each command and holds query results in an output register.
// ----------------------------------------------------------------------------
module psum_back (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cmd_valid,
    output logic                        cmd_ready,
    input  psum_pkg::cmd_t              cmd,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [psum_pkg::DATA_W-1:0] m_tdata,
    output psum_pkg::psum_status_t      stat
);
    import psum_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    logic [DATA_W-1:0] node_mem [MAX_ENTRIES];
    logic [DATA_W-1:0] rd_data_reg;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;
    logic              func_reg, func_next;
    logic [WPOS_W-1:0] pos_reg, pos_next;
    logic [DATA_W-1:0] delta_reg, delta_next;
    logic [CFG_W-1:0]  size_reg, size_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_addr_reg, pend_addr_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;

    logic [WPOS_W-1:0] pos_m1;
    logic [WPOS_W-1:0] pos_lsb;
    logic              issue;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    assign pos_m1  = pos_reg - WPOS_W'(1);
    assign pos_lsb = pos_reg & (~pos_reg + WPOS_W'(1));
    assign rd_addr = pos_m1[IDX_W-1:0];

    assign cmd_ready     = state_reg == ST_IDLE;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign stat.clearing = state_reg == ST_CLEAR;
    assign stat.busy     = (state_reg == ST_WALK) || (state_reg == ST_FINISH);

    always_comb
    begin
        if (func_reg == FUNC_QUERY)
        begin
            issue = pos_reg != '0;
        end
        else
        begin
            issue = (pos_reg != '0) && (pos_reg <= WPOS_W'(size_reg));
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        func_next      = func_reg;
        pos_next       = pos_reg;
        delta_next     = delta_reg;
        size_next      = size_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data_reg + delta_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(MAX_ENTRIES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    func_next  = cmd.func;
                    pos_next   = cmd.start_pos;
                    delta_next = cmd.delta;
                    size_next  = cmd.size;
                    acc_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (pend_reg)
                begin
                    if (func_reg == FUNC_QUERY)
                    begin
                        acc_next = acc_reg + rd_data_reg;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
                pend_next = issue;
                if (issue)
                begin
                    rd_en          = 1'b1;
                    pend_addr_next = rd_addr;
                    if (func_reg == FUNC_QUERY)
                    begin
                        pos_next = pos_reg & pos_m1;
                    end
                    else
                    begin
                        pos_next = pos_reg + pos_lsb;
                    end
                end
                else
                begin
                    state_next = (func_reg == FUNC_QUERY) ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        pos_reg       <= pos_next;
        delta_reg     <= delta_next;
        size_reg      <= size_next;
        acc_reg       <= acc_next;
        pend_addr_reg <= pend_addr_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= node_mem[rd_addr];
        end
    end

endmodule : psum_back
`default_nettype wire

// ----- hw/rtl/prefix_sum_tree.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Prefix sum tree
// Binary indexed tree over up to 1024 signed 32-bit elements with update and
// prefix-sum query operations.
//
// Items arrive on the s_ group: s_tuser selects the operation (0 adds delta
// to an element, 1 asks for the prefix sum up to index). Each query gives one
// transfer on the m_ group; updates give none. The cfg channel writes the
// number of elements in use and is always ready; write it only while idle.
// An item is registered in the queue stage, then the walk reads one tree
// node per cycle from the single node memory: an update reads the nodes on
// its upward path, a query one node for each set bit of index+1.
// Out-of-range updates are dropped at the input; out-of-range queries return
// zero. After reset the node memory is cleared, all 1024 entries, during
// which s_tready stays low. A stalled receiver holds the result in the
// output register; later items go on walking until a second query waits
// to finish, the two-entry queue then fills and the input stalls.
// ----------------------------------------------------------------------------
module prefix_sum_tree (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire [psum_pkg::CFG_W-1:0]     cfg_data,   // entries_in_use
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire [psum_pkg::IN_DATA_W-1:0] s_tdata,    // index[9:0], delta[41:10]
    input  wire [0:0]                     s_tuser,    // func[0]
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [psum_pkg::DATA_W-1:0]   m_tdata     // sum[31:0]
);
    import psum_pkg::*;

    cmd_t         front_cmd;
    logic         front_valid;
    logic         front_ready;
    cmd_t         back_cmd;
    logic         back_valid;
    logic         back_ready;
    psum_status_t stat;

    psum_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .clearing  (stat.clearing),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    psum_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    psum_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .stat      (stat)
    );

    a_no_input_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !stat.clearing
    ) else $error("Input transfer accepted while node memory is being cleared");

    a_result_from_walk : assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(stat.busy)
    ) else $error("Result appeared without a preceding tree walk");

    a_command_starts_walk : assert property (
        @(posedge clk) disable iff (!rst_n)
        (back_valid && back_ready) |=> stat.busy
    ) else $error("Dequeued command did not start a walk");

endmodule : prefix_sum_tree
`default_nettype wire

// ----- verif/tb_prefix_sum_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prefix sum tree testbench
// Drives update and query transfers into the tree under several sizes and
// keeps its own copy of the node store. Each query's sum is predicted when
// the transfer is accepted and checked against the result stream in order.
// Both sides idle at random, and the result side is held off once for a
// long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_prefix_sum_tree;

    import psum_pkg::*;

    typedef struct packed {
        logic              func;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] delta;
    } op_t;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] sum;
    } sum_expect_t;

    localparam int PAD_W       = IN_DATA_W - IDX_W - DATA_W;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 30;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [DATA_W-1:0]    m_tdata;

    logic [DATA_W-1:0] node_mem [MAX_ENTRIES];
    logic [CFG_W-1:0]  size_reg;

    op_t         pending_ops [$];
    sum_expect_t sums_expected [$];
    op_t         on_bus;

    int unsigned queued_ops     = 0;
    int unsigned accepted_items = 0;
    int unsigned hold_left      = 0;
    logic        hold_done      = 1'b0;
    logic        calm           = 1'b0;
    int unsigned fault_count    = 0;
    int unsigned report_count   = 0;

    prefix_sum_tree u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_size();
        return (size_reg > MAX_ENTRIES) ? MAX_ENTRIES : size_reg;
    endfunction

    function automatic void tree_add_delta(input logic [IDX_W-1:0] idx,
                                           input logic [DATA_W-1:0] d);
        int unsigned n;
        int unsigned pos;
        n = eff_size();
        if (idx < n)
        begin
            pos = idx + 1;
            while (pos <= n)
            begin
                node_mem[pos - 1] = node_mem[pos - 1] + d;
                pos = pos + (pos & (~pos + 1));
            end
        end
    endfunction

    function automatic logic [DATA_W-1:0] tree_prefix_sum(input logic [IDX_W-1:0] idx);
        int unsigned       n;
        int unsigned       pos;
        logic [DATA_W-1:0] acc;
        n   = eff_size();
        acc = '0;
        if (idx >= n)
            return '0;
        pos = idx + 1;
        while (pos > 0)
        begin
            acc = acc + node_mem[pos - 1];
            pos = pos & (pos - 1);
        end
        return acc;
    endfunction

    function automatic void push_op(input logic f, input int unsigned idx,
                                    input logic [DATA_W-1:0] d);
        op_t it;
        it.func  = f;
        it.index = idx[IDX_W-1:0];
        it.delta = d;
        pending_ops.push_back(it);
        queued_ops++;
    endfunction

    function automatic void push_random(input int unsigned count);
        int unsigned       n;
        int unsigned       idx;
        logic              f;
        logic [DATA_W-1:0] d;
        n = eff_size();
        repeat (count)
        begin
            f = ($urandom_range(99) < 45) ? FUNC_QUERY : FUNC_ADD;
            if (n != 0 && $urandom_range(99) < 85)
                idx = $urandom_range(n - 1);
            else
                idx = $urandom_range(MAX_ENTRIES - 1);
            case ($urandom_range(3))
                0: d = $urandom;
                1: d = $urandom_range(200) - 100;
                2: d = $urandom_range(15);
                default: d = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            endcase
            push_op(f, idx, d);
        end
    endfunction

    task automatic settle();
        while (accepted_items != queued_ops || sums_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_reg = v;
    endtask

    // The sender: one transfer on the bus at a time, taken from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (on_bus.func == FUNC_ADD)
                    tree_add_delta(on_bus.index, on_bus.delta);
                else
                    sums_expected.push_back('{on_bus.index, tree_prefix_sum(on_bus.index)});
                accepted_items <= accepted_items + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= 18))
                begin
                    on_bus = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_bus.func;
                    s_tdata  <= {{PAD_W{1'b0}}, on_bus.delta, on_bus.index};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // A single long hold-off of the result side once the first phase is under way.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted_items >= 60)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (sums_expected.size() == 0)
                begin
                    fault_count++;
                    if (report_count < 10)
                    begin
                        report_count++;
                        $display("Unexpected sum transfer: got %h", m_tdata);
                    end
                end
                else if (sums_expected[0].sum !== m_tdata)
                begin
                    fault_count++;
                    if (report_count < 10)
                    begin
                        report_count++;
                        $display("Sum mismatch at index %0d: expected %h, got %h",
                                 sums_expected[0].index, sums_expected[0].sum, m_tdata);
                    end
                    void'(sums_expected.pop_front());
                end
                else
                begin
                    void'(sums_expected.pop_front());
                end
            end
            m_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 18);
        end
    end

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
            node_mem[i] = '0;
        size_reg = CFG_W'(MAX_ENTRIES);
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full size from reset: extremes of index and delta, and a wrapping sum.
        push_op(FUNC_ADD, 0, 32'h7FFF_FFFF);
        push_op(FUNC_ADD, 1023, 32'h8000_0000);
        push_op(FUNC_ADD, 512, 32'hFFFF_FFFF);
        push_op(FUNC_ADD, 5, 32'h0000_0000);
        push_op(FUNC_QUERY, 0, 32'hFFFF_FFFF);
        push_op(FUNC_QUERY, 1023, 32'h0000_0000);
        push_op(FUNC_QUERY, 511, 32'h1234_5678);
        push_op(FUNC_QUERY, 512, 32'h0000_0000);
        push_op(FUNC_ADD, 0, 32'h0000_0001);
        push_op(FUNC_QUERY, 0, 32'h0000_0000);
        push_op(FUNC_QUERY, 1023, 32'h0000_0000);
        push_random(180);
        settle();

        // The size shrinks over a populated store, which is not rebuilt.
        write_size(11'd37);
        @(posedge clk);
        push_op(FUNC_QUERY, 36, 32'h0);
        push_op(FUNC_QUERY, 37, 32'h0);
        push_op(FUNC_ADD, 37, 32'h5);
        push_op(FUNC_ADD, 1023, 32'h5);
        push_op(FUNC_QUERY, 1023, 32'h0);
        push_op(FUNC_ADD, 36, 32'h9);
        push_op(FUNC_QUERY, 36, 32'h0);
        push_random(100);
        settle();

        write_size(11'd0);
        @(posedge clk);
        push_op(FUNC_QUERY, 0, 32'h0);
        push_op(FUNC_ADD, 0, 32'h7);
        push_op(FUNC_QUERY, 1023, 32'h0);
        push_random(10);
        settle();

        write_size(11'd1);
        @(posedge clk);
        push_op(FUNC_ADD, 0, 32'h3);
        push_op(FUNC_QUERY, 0, 32'h0);
        push_op(FUNC_QUERY, 1, 32'h0);
        push_random(20);
        settle();

        // A size above the maximum acts as the maximum; this phase runs without idling.
        write_size(11'h7FF);
        @(posedge clk);
        calm = 1'b1;
        push_op(FUNC_QUERY, 1023, 32'h0);
        push_random(160);
        settle();
        calm = 1'b0;

        write_size(11'd300);
        @(posedge clk);
        push_random(100);
        settle();

        write_size(CFG_W'(MAX_ENTRIES));
        @(posedge clk);
        push_random(80);
        settle();

        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
